// ===== sv/m3i_pkg.sv =====
package m3i_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned SHIFT      = 2 * FRAC_BITS;
  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned N_W        = 2 * ELEM_W;
  localparam int unsigned DET_W      = 98;
  localparam int unsigned MAG_W      = DET_W - 1;
  localparam int unsigned NUM_W      = N_W + SHIFT;
  localparam int unsigned Q_W        = 32;
  localparam int unsigned DIV_STAGES = Q_W;
  localparam int unsigned NUM_ELEM   = 9;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [N_W-1:0]    minor_t;
  typedef logic [N_W-1:0]           nmag_t;
  typedef logic [MAG_W-1:0]         mag_t;
  typedef logic [Q_W-1:0]           quo_t;

  typedef struct packed {
    mag_t dmag;
    logic neg;
    logic zero;
  } det_info_t;

  // minor k = m[A]*m[B] - m[C]*m[D], row-major element indexes
  localparam int unsigned MIN_A [NUM_ELEM] = '{4, 7, 1, 5, 0, 3, 3, 6, 0};
  localparam int unsigned MIN_B [NUM_ELEM] = '{8, 2, 5, 6, 8, 2, 7, 1, 4};
  localparam int unsigned MIN_C [NUM_ELEM] = '{5, 1, 4, 3, 6, 0, 6, 0, 1};
  localparam int unsigned MIN_D [NUM_ELEM] = '{7, 8, 2, 8, 2, 5, 4, 7, 3};

endpackage

// ===== sv/m3i_minors.sv =====
module m3i_minors
  import m3i_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  elem_t  mat_i [NUM_ELEM],
  output logic   valid_o,
  output elem_t  row0_o [3],
  output minor_t minor_o [NUM_ELEM]
);

  logic   vld_q [2];
  minor_t pab_q [NUM_ELEM];
  minor_t pcd_q [NUM_ELEM];
  elem_t  r0a_q [3];
  elem_t  r0b_q [3];
  minor_t n_q   [NUM_ELEM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
      vld_q[1] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      vld_q[1] <= vld_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        pab_q[k] <= mat_i[MIN_A[k]] * mat_i[MIN_B[k]];
        pcd_q[k] <= mat_i[MIN_C[k]] * mat_i[MIN_D[k]];
        n_q[k]   <= pab_q[k] - pcd_q[k];
      end
      for (int k = 0; k < 3; k++) begin
        r0a_q[k] <= mat_i[k];
        r0b_q[k] <= r0a_q[k];
      end
    end
  end

  assign valid_o = vld_q[1];
  assign row0_o  = r0b_q;
  assign minor_o = n_q;

endmodule

// ===== sv/m3i_det.sv =====
module m3i_det
  import m3i_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  elem_t     row0_i [3],
  input  minor_t    minor_i [NUM_ELEM],
  output logic      valid_o,
  output nmag_t     nmag_o [NUM_ELEM],
  output logic      nneg_o [NUM_ELEM],
  output det_info_t det_o
);

  logic                    vld_q [4];
  logic signed [64:0]      pl_q [3];
  logic signed [N_W-1:0]   ph_q [3];
  logic signed [DET_W-1:0] t_q [3];
  logic signed [DET_W-1:0] det_q;
  minor_t                  nc_q [NUM_ELEM];
  minor_t                  nd_q [NUM_ELEM];
  minor_t                  ne_q [NUM_ELEM];
  nmag_t                   nmag_q [NUM_ELEM];
  logic                    nneg_q [NUM_ELEM];
  det_info_t               det_info_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < 4; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        pl_q[i] <= row0_i[i] * $signed({1'b0, minor_i[3*i][31:0]});
        ph_q[i] <= row0_i[i] * $signed(minor_i[3*i][N_W-1:32]);
        t_q[i]  <= (DET_W'(ph_q[i]) <<< 32) + DET_W'(pl_q[i]);
      end
      det_q <= t_q[0] + t_q[1] + t_q[2];
      for (int k = 0; k < NUM_ELEM; k++) begin
        nc_q[k]   <= minor_i[k];
        nd_q[k]   <= nc_q[k];
        ne_q[k]   <= nd_q[k];
        nneg_q[k] <= ne_q[k][N_W-1];
        nmag_q[k] <= ne_q[k][N_W-1] ? N_W'(0 - ne_q[k]) : N_W'(ne_q[k]);
      end
      det_info_q.neg  <= det_q[DET_W-1];
      det_info_q.zero <= (det_q == '0);
      det_info_q.dmag <= det_q[DET_W-1] ? MAG_W'(0 - det_q) : MAG_W'(det_q);
    end
  end

  assign valid_o = vld_q[3];
  assign nmag_o  = nmag_q;
  assign nneg_o  = nneg_q;
  assign det_o   = det_info_q;

endmodule

// ===== sv/m3i_div.sv =====
module m3i_div
  import m3i_pkg::*;
(
  input  nmag_t nmag_i,
  input  mag_t  dmag_i,
  output logic  big_o,
  output mag_t  rem_o,
  output quo_t  lo_o
);

  localparam int unsigned WIDE_W = MAG_W + Q_W;

  logic [NUM_W-1:0] num;

  // quotient of 2^Q_W or more can only saturate
  assign num   = {nmag_i, SHIFT'(0)};
  assign big_o = WIDE_W'(num) >= {dmag_i, Q_W'(0)};
  assign rem_o = MAG_W'(num >> Q_W);
  assign lo_o  = num[Q_W-1:0];

endmodule

// ===== sv/m3i_div_core.sv =====
module m3i_div_core
  import m3i_pkg::*;
(
  input  mag_t rem_i,
  input  quo_t quo_i,
  input  quo_t lo_i,
  input  mag_t dmag_i,
  output mag_t rem_o,
  output quo_t quo_o,
  output quo_t lo_o
);

  logic [MAG_W:0] r_sh;
  logic           ge;

  // one restoring step, retires one quotient bit
  assign r_sh  = {rem_i, lo_i[Q_W-1]};
  assign ge    = r_sh >= {1'b0, dmag_i};
  assign rem_o = ge ? MAG_W'(r_sh - {1'b0, dmag_i}) : MAG_W'(r_sh);
  assign quo_o = {quo_i[Q_W-2:0], ge};
  assign lo_o  = {lo_i[Q_W-2:0], 1'b0};

endmodule

// ===== sv/m3i_divider.sv =====
module m3i_divider
  import m3i_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  nmag_t     nmag_i [NUM_ELEM],
  input  logic      nneg_i [NUM_ELEM],
  input  det_info_t det_i,
  output logic      valid_o,
  output quo_t      quo_o [NUM_ELEM],
  output logic      big_o [NUM_ELEM],
  output logic      neg_o [NUM_ELEM],
  output det_info_t det_o
);

  logic      vld_q [DIV_STAGES+1];
  mag_t      rem_q [DIV_STAGES+1][NUM_ELEM];
  quo_t      quo_q [DIV_STAGES+1][NUM_ELEM];
  quo_t      lo_q  [DIV_STAGES+1][NUM_ELEM];
  logic      big_q [DIV_STAGES+1][NUM_ELEM];
  logic      neg_q [DIV_STAGES+1][NUM_ELEM];
  det_info_t det_q [DIV_STAGES+1];

  mag_t      rem_d [DIV_STAGES+1][NUM_ELEM];
  quo_t      quo_d [DIV_STAGES+1][NUM_ELEM];
  quo_t      lo_d  [DIV_STAGES+1][NUM_ELEM];
  logic      big_d [NUM_ELEM];

  // stage 0 aligns the dividend, later stages retire one quotient bit each
  for (genvar l = 0; l < NUM_ELEM; l++) begin : g_lane
    m3i_div u_align (
      .nmag_i (nmag_i[l]),
      .dmag_i (det_i.dmag),
      .big_o  (big_d[l]),
      .rem_o  (rem_d[0][l]),
      .lo_o   (lo_d[0][l])
    );
    assign quo_d[0][l] = '0;
    for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
      m3i_div_core u_step (
        .rem_i  (rem_q[s-1][l]),
        .quo_i  (quo_q[s-1][l]),
        .lo_i   (lo_q[s-1][l]),
        .dmag_i (det_q[s-1].dmag),
        .rem_o  (rem_d[s][l]),
        .quo_o  (quo_d[s][l]),
        .lo_o   (lo_d[s][l])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= DIV_STAGES; s++) vld_q[s] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int s = 1; s <= DIV_STAGES; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q[0] <= det_i;
      for (int l = 0; l < NUM_ELEM; l++) begin
        big_q[0][l] <= big_d[l];
        neg_q[0][l] <= nneg_i[l] ^ det_i.neg;
      end
      for (int s = 0; s <= DIV_STAGES; s++) begin
        for (int l = 0; l < NUM_ELEM; l++) begin
          rem_q[s][l] <= rem_d[s][l];
          quo_q[s][l] <= quo_d[s][l];
          lo_q[s][l]  <= lo_d[s][l];
        end
      end
      for (int s = 1; s <= DIV_STAGES; s++) begin
        det_q[s] <= det_q[s-1];
        for (int l = 0; l < NUM_ELEM; l++) begin
          big_q[s][l] <= big_q[s-1][l];
          neg_q[s][l] <= neg_q[s-1][l];
        end
      end
    end
  end

  assign valid_o = vld_q[DIV_STAGES];
  assign det_o   = det_q[DIV_STAGES];
  always_comb begin
    for (int l = 0; l < NUM_ELEM; l++) begin
      quo_o[l] = quo_q[DIV_STAGES][l];
      big_o[l] = big_q[DIV_STAGES][l];
      neg_o[l] = neg_q[DIV_STAGES][l];
    end
  end

endmodule

// ===== sv/matrix3x3_inverse.sv =====
// channel  | dir | tdata                                  | tuser
// s_axis   | in  | a00..a22, 32 bits each, a00 lowest     | -
// m_axis   | out | inv00..inv22 then determinant, 32 each | singular, overflow
//
// one matrix per cycle unless frozen by a stall; 2 minor, 4 determinant,
// 33 divider (first aligns, then one quotient bit each), 1 output register
// reset clears only the valid bits; there is no state between matrices
// a stall on m_axis parks one transaction in a skid register, then freezes
// the whole pipeline and drops s_axis_tready in the next cycle
module matrix3x3_inverse
  import m3i_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,   // a00 a01 a02 a10 a11 a12 a20 a21 a22
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [319:0] m_axis_tdata,   // inv00 .. inv22 determinant
  output logic [1:0]   m_axis_tuser    // singular overflow
);

  logic      en;
  elem_t     mat [NUM_ELEM];
  logic      mn_valid;
  elem_t     mn_row0 [3];
  minor_t    mn_minor [NUM_ELEM];
  logic      dt_valid;
  nmag_t     dt_nmag [NUM_ELEM];
  logic      dt_nneg [NUM_ELEM];
  det_info_t dt_info;
  logic      dv_valid;
  quo_t      dv_quo [NUM_ELEM];
  logic      dv_big [NUM_ELEM];
  logic      dv_neg [NUM_ELEM];
  det_info_t dv_info;

  logic         out_valid_q;
  logic [319:0] out_data_q;
  logic [319:0] out_data_d;
  logic [1:0]   out_user_q;
  logic [1:0]   out_user_d;
  logic         skid_valid_q;
  logic [319:0] skid_data_q;
  logic [1:0]   skid_user_q;
  logic         out_stall;

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;
  assign out_stall     = out_valid_q && !m_axis_tready;

  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) mat[k] = s_axis_tdata[ELEM_W*k +: ELEM_W];
  end

  m3i_minors u_minors (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .mat_i   (mat),
    .valid_o (mn_valid),
    .row0_o  (mn_row0),
    .minor_o (mn_minor)
  );

  m3i_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mn_valid),
    .row0_i  (mn_row0),
    .minor_i (mn_minor),
    .valid_o (dt_valid),
    .nmag_o  (dt_nmag),
    .nneg_o  (dt_nneg),
    .det_o   (dt_info)
  );

  m3i_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dt_valid),
    .nmag_i  (dt_nmag),
    .nneg_i  (dt_nneg),
    .det_i   (dt_info),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .big_o   (dv_big),
    .neg_o   (dv_neg),
    .det_o   (dv_info)
  );

  always_comb begin
    logic        ovf;
    logic        sat;
    quo_t        val;
    mag_t        dsh;
    ovf = 1'b0;
    for (int l = 0; l < NUM_ELEM; l++) begin
      sat = dv_big[l] || (dv_neg[l] ? (dv_quo[l] > 32'h8000_0000) : dv_quo[l][Q_W-1]);
      val = dv_neg[l] ? Q_W'(0 - dv_quo[l]) : dv_quo[l];
      if (sat) val = dv_neg[l] ? 32'h8000_0000 : 32'h7fff_ffff;
      ovf = ovf | sat;
      out_data_d[Q_W*l +: Q_W] = val;
    end
    dsh = dv_info.dmag >> SHIFT;
    sat = dv_info.neg ? (dsh > MAG_W'(32'h8000_0000)) : (dsh > MAG_W'(32'h7fff_ffff));
    val = dv_info.neg ? Q_W'(0 - dsh[Q_W-1:0]) : dsh[Q_W-1:0];
    if (sat) val = dv_info.neg ? 32'h8000_0000 : 32'h7fff_ffff;
    ovf = ovf | sat;
    out_data_d[Q_W*NUM_ELEM +: Q_W] = val;
    out_user_d = {ovf, 1'b0};
    if (dv_info.zero) begin
      out_data_d = '0;
      out_user_d = 2'b01;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (m_axis_tready) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (out_stall) begin
      skid_valid_q <= dv_valid;
    end else begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_axis_tready) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
      end
    end else if (out_stall) begin
      skid_data_q <= out_data_d;
      skid_user_q <= out_user_d;
    end else begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
